// ===== rtl/core/bmh_pkg.sv =====
package bmh_pkg;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned NUM_WORDS = 8;
   localparam int unsigned POS_W     = 3;
   localparam int unsigned BYTE_W    = 8;

   localparam int unsigned ABSORB_SHIFT = 17;
   localparam int unsigned ROT_A        = 7;
   localparam int unsigned ROT_B        = 13;
   localparam int unsigned ROT_C        = 17;

   localparam logic [WORD_W-1:0] INIT_WORDS [NUM_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef enum logic [3:0] {
      ST_ABSORB = 4'b0001,
      ST_ALIGN  = 4'b0010,
      ST_MIX    = 4'b0100,
      ST_EMIT   = 4'b1000
   } bmh_state_type;

   // controller -> datapath
   typedef struct packed {
      logic absorb;      // fold the input byte in and advance the ring
      logic align;       // advance the ring only, position counts along
      logic mix;         // one finalization word update, then advance
      logic emit_shift;  // advance the ring after a result beat
      logic reinit;      // reload the initial words
   } bmh_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pos_zero;
   } bmh_status_type;

endpackage

// ===== rtl/core/byte_mix_hash_256.sv =====
// Byte-serial 256-bit mixing hash. Message bytes arrive on the req stream, one
// per beat, with req_tlast on the final byte; a byte is absorbed in the cycle it
// is accepted, so absorption runs at one byte per clock. After the last byte the
// block stops taking input and finalizes: first it turns its word ring back into
// order, advancing it until the byte position wraps to zero, and hands over to
// the mixer, then it runs FINAL_ROUNDS*8 mixing steps, one word update per cycle
// on a single rotate/add/xor unit. The digest then leaves as eight rsp beats,
// word 0 first, each word holding four digest bytes least significant byte
// first, with rsp_tuser giving the word index and rsp_tlast set on word 7. The
// next message is accepted in the cycle after the last digest beat. Every
// message must have at least one byte.
module byte_mix_hash_256
   import bmh_pkg::*;
#(
   parameter int unsigned FINAL_ROUNDS = 8
)
(
   input  logic          clock,
   input  logic          reset,
   // message bytes
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] data_byte
   input  logic          req_tlast,   // end_of_message
   // digest words
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [31:0]   rsp_tdata,   // [31:0] digest_word
   output logic [2:0]    rsp_tuser,   // [2:0] word_index
   output logic          rsp_tlast    // last_word
);

   bmh_cmd_type     cmd;
   bmh_status_type  status;

   // Controller: sequences absorb, realign, mix and emit phases.
   bmh_ctrl #(
      .FINAL_ROUNDS (FINAL_ROUNDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_last   (req_tlast),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_index (rsp_tuser),
      .out_last  (rsp_tlast),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: eight-word ring with the absorb and mix units on fixed taps;
   // slot zero of the ring drives the digest output.
   bmh_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .data_byte (req_tdata),
      .status    (status),
      .head_word (rsp_tdata)
   );

endmodule

// ===== rtl/core/bmh_dp.sv =====
module bmh_dp
   import bmh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  bmh_cmd_type          cmd,
   input  logic [BYTE_W-1:0]    data_byte,
   output bmh_status_type       status,
   output logic [WORD_W-1:0]    head_word
);

   // Words live in a ring: slot 0 always holds the word to work on next.
   logic [WORD_W-1:0] ring_ff [NUM_WORDS];
   logic [WORD_W-1:0] ring_in [NUM_WORDS];
   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;

   logic [WORD_W-1:0] abs_x0;
   logic [WORD_W-1:0] abs_x1;
   logic [WORD_W-1:0] abs_x2;
   logic [WORD_W-1:0] mix_new;
   logic [WORD_W-1:0] byte_lane;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                              input int unsigned n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   always_comb begin
      byte_lane = {{(WORD_W-BYTE_W){1'b0}}, data_byte} << {pos_ff[1:0], 3'b000};
      abs_x0    = ring_ff[0] ^ byte_lane;
      abs_x1    = ring_ff[1] + abs_x0;
      abs_x2    = ring_ff[2] ^ (abs_x1 >> ABSORB_SHIFT);

      mix_new = ((ring_ff[0] ^ rotl(ring_ff[NUM_WORDS-1], ROT_A))
                 + rotl(ring_ff[1], ROT_B)) ^ rotl(ring_ff[2], ROT_C);
   end

   always_comb begin
      ring_in = ring_ff;
      pos_in  = pos_ff;
      if (cmd.reinit) begin
         ring_in = INIT_WORDS;
         pos_in  = '0;
      end else if (cmd.absorb) begin
         for (int k = 0; k < NUM_WORDS - 1; k++) begin
            ring_in[k] = ring_ff[k+1];
         end
         ring_in[0]           = abs_x1;
         ring_in[1]           = abs_x2;
         ring_in[NUM_WORDS-1] = abs_x0;
         pos_in               = pos_ff + 1'b1;
      end else if (cmd.align || cmd.mix || cmd.emit_shift) begin
         for (int k = 0; k < NUM_WORDS - 1; k++) begin
            ring_in[k] = ring_ff[k+1];
         end
         ring_in[NUM_WORDS-1] = cmd.mix ? mix_new : ring_ff[0];
         if (cmd.align) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff <= INIT_WORDS;
         pos_ff  <= '0;
      end else begin
         ring_ff <= ring_in;
         pos_ff  <= pos_in;
      end
   end

   assign status.pos_zero = (pos_ff == '0);
   assign head_word       = ring_ff[0];

   // mixing must only start once word zero sits in slot zero
   a_mix_aligned: assert property (@(posedge clock) disable iff (reset)
      cmd.mix |-> pos_ff == '0)
      else $error("mix step with ring out of alignment");

   a_reinit_pos: assert property (@(posedge clock) disable iff (reset)
      cmd.reinit |=> pos_ff == '0 && ring_ff[0] == INIT_WORDS[0])
      else $error("reload did not restore initial state");

endmodule

// ===== rtl/core/bmh_ctrl.sv =====
module bmh_ctrl
   import bmh_pkg::*;
#(
   parameter int unsigned FINAL_ROUNDS = 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_last,
   output logic               in_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [POS_W-1:0]   out_index,
   output logic               out_last,
   input  bmh_status_type     status,
   output bmh_cmd_type        cmd
);

   localparam int unsigned MIX_STEPS = FINAL_ROUNDS * NUM_WORDS;
   localparam int unsigned MIX_CNT_W = $clog2(MIX_STEPS);

   bmh_state_type          state_ff;
   bmh_state_type          state_in;
   logic [MIX_CNT_W-1:0]   mix_cnt_ff;
   logic [MIX_CNT_W-1:0]   mix_cnt_in;
   logic [POS_W-1:0]       idx_ff;
   logic [POS_W-1:0]       idx_in;
   logic                   in_beat;
   logic                   out_beat;

   assign in_ready  = (state_ff == ST_ABSORB);
   assign out_valid = (state_ff == ST_EMIT);
   assign out_index = idx_ff;
   assign out_last  = (idx_ff == POS_W'(NUM_WORDS - 1));
   assign in_beat   = in_valid && in_ready;
   assign out_beat  = out_valid && out_ready;

   always_comb begin
      state_in   = state_ff;
      mix_cnt_in = mix_cnt_ff;
      idx_in     = idx_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_ABSORB: begin
            if (in_beat) begin
               cmd.absorb = 1'b1;
               if (in_last) begin
                  state_in   = ST_ALIGN;
                  mix_cnt_in = MIX_CNT_W'(MIX_STEPS - 1);
               end
            end
         end
         ST_ALIGN: begin
            if (status.pos_zero) begin
               state_in = ST_MIX;
            end else begin
               cmd.align = 1'b1;
            end
         end
         ST_MIX: begin
            cmd.mix    = 1'b1;
            mix_cnt_in = mix_cnt_ff - 1'b1;
            if (mix_cnt_ff == '0) begin
               state_in = ST_EMIT;
               idx_in   = '0;
            end
         end
         ST_EMIT: begin
            if (out_beat) begin
               idx_in = idx_ff + 1'b1;
               if (out_last) begin
                  cmd.reinit = 1'b1;
                  state_in   = ST_ABSORB;
               end else begin
                  cmd.emit_shift = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_ABSORB;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_ABSORB;
         mix_cnt_ff <= '0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         mix_cnt_ff <= mix_cnt_in;
         idx_ff     <= idx_in;
      end
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(in_ready && out_valid))
      else $error("input taken while digest is being emitted");

   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      (out_beat && out_last) |=> state_ff == ST_ABSORB)
      else $error("block did not return to absorbing after last word");

   a_mix_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX && mix_cnt_ff != '0) |=> state_ff == ST_MIX)
      else $error("mixing ended early");

endmodule

// ===== tb/sv/byte_mix_hash_256_tb.sv =====
module byte_mix_hash_256_tb;
   import bmh_pkg::*;

   localparam int unsigned FINAL_ROUNDS = 8;
   localparam int unsigned TOTAL_BYTES  = 390;   // random bytes to push after the directed part
   localparam int unsigned DRAIN_CYCLES = 120;   // idle time to watch for stray digest beats after the last owed one
   localparam int unsigned RUN_LIMIT    = 4_000_000;

   // one expected digest beat
   typedef struct {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_beat_type;

   // Tracks the hash state of the message in flight and holds the digest
   // beats that are owed by the block.
   class digest_tracker;
      logic [31:0]     words [NUM_WORDS];
      logic [2:0]      pos;
      digest_beat_type due [$];
      int unsigned     mismatches;
      int unsigned     words_checked;
      int unsigned     bytes_absorbed;
      int unsigned     messages;

      function new();
         mismatches     = 0;
         words_checked  = 0;
         bytes_absorbed = 0;
         messages       = 0;
         restart();
      endfunction

      function void restart();
         int i;
         for (i = 0; i < NUM_WORDS; i++) words[i] = INIT_WORDS[i];
         pos = '0;
      endfunction

      function logic [31:0] rotl(logic [31:0] v, int unsigned n);
         if (n % 32 == 0) return v;
         return (v << n) | (v >> (32 - n));
      endfunction

      function void absorb(logic [7:0] b);
         logic [2:0] p1;
         logic [2:0] p2;
         p1 = pos + 3'd1;
         p2 = pos + 3'd2;
         words[pos] ^= {24'h0, b} << {pos[1:0], 3'b000};
         words[p1]  += words[pos];
         words[p2]  ^= words[p1] >> ABSORB_SHIFT;
         pos = p1;
      endfunction

      function void finalize();
         int r;
         int i;
         logic [2:0] cur;
         logic [2:0] prev;
         logic [2:0] next1;
         logic [2:0] next2;
         digest_beat_type beat;
         for (r = 0; r < FINAL_ROUNDS; r++) begin
            for (i = 0; i < NUM_WORDS; i++) begin
               cur   = i[2:0];
               prev  = cur - 3'd1;
               next1 = cur + 3'd1;
               next2 = cur + 3'd2;
               words[cur] ^= rotl(words[prev], ROT_A);
               words[cur] += rotl(words[next1], ROT_B);
               words[cur] ^= rotl(words[next2], ROT_C);
            end
         end
         for (i = 0; i < NUM_WORDS; i++) begin
            beat.word  = words[i];
            beat.index = i[2:0];
            beat.last  = (i == NUM_WORDS - 1);
            due = {due, beat};
         end
      endfunction

      // note one accepted message byte
      function void note_byte(logic [7:0] b, logic eom);
         absorb(b);
         bytes_absorbed++;
         if (eom) begin
            finalize();
            messages++;
            restart();
         end
      endfunction

      // compare one accepted digest beat with the oldest one owed
      function void check_word(logic [31:0] data, logic [2:0] index, logic last);
         digest_beat_type want;
         if (due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected digest beat word=%h index=%0d last=%b",
                        data, index, last);
            return;
         end
         want = due.pop_front();
         words_checked++;
         if (data !== want.word || index !== want.index || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: digest beat expected word=%h index=%0d last=%b,",
                         " got word=%h index=%0d last=%b"},
                        want.word, want.index, want.last, data, index, last);
         end
      endfunction

      function int unsigned pending();
         return due.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Block under test and its stimulus signals; every input starts known.
   // ---------------------------------------------------------------------
   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] data_byte
   logic        req_tlast  = 1'b0;    // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [31:0] digest_word
   logic [2:0]  rsp_tuser;            // [2:0] word_index
   logic        rsp_tlast;            // last_word

   digest_tracker track;

   logic [7:0]  msg_buf [0:127];      // bytes of the next message to send
   logic        steady_flow = 1'b0;   // hold rsp_tready high while set
   int unsigned stall_left  = 0;

   byte_mix_hash_256 #(.FINAL_ROUNDS(FINAL_ROUNDS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs; far above the slowest legal run.
   initial begin
      #(RUN_LIMIT);
      $display("Watchdog expired with %0d digest beats still owed", track.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver back-pressure: mostly short stalls, a few long ones, none at all
   // while steady_flow is set.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 99) < 25) begin
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Check every digest beat taken at this edge; values read here are the
   // ones sampled by the edge, since all drivers use nonblocking updates.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         track.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Idle gap ahead of a byte: zero in a quiet message, else mostly short.
   function automatic int unsigned pick_gap(input logic quiet);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Present one byte, hold it until the handshake completes, then note it.
   task automatic send_byte(input logic [7:0] b, input logic eom, input int unsigned gap);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eom;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track.note_byte(b, eom);
   endtask

   // Send msg_buf[0..len-1] as one message, tlast on the final beat.
   task automatic send_message(input int unsigned len, input logic quiet);
      int unsigned k;
      for (k = 0; k < len; k++)
         send_byte(msg_buf[k], k == len - 1, pick_gap(quiet));
   endtask

   initial begin
      int unsigned i;
      int unsigned len;
      int unsigned sent;
      int unsigned roll;

      track = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: single-byte messages at both byte extremes.
      msg_buf[0] = 8'h00;
      send_message(1, 1'b1);
      msg_buf[0] = 8'hFF;
      send_message(1, 1'b0);

      // Eight bytes: position wraps back to zero, no ring realignment needed.
      for (i = 0; i < 8; i++) msg_buf[i] = 8'hFF;
      send_message(8, 1'b1);

      // Walk a one through every data bit, then one byte past the wrap.
      for (i = 0; i < 8; i++) msg_buf[i] = 8'h01 << i;
      msg_buf[8] = 8'h00;
      send_message(9, 1'b0);

      // Short message ending mid-ring with alternating bit patterns.
      msg_buf[0] = 8'hAA;
      msg_buf[1] = 8'h55;
      msg_buf[2] = 8'hC3;
      send_message(3, 1'b0);

      // Random messages: mostly short, some single bytes, a few long ones
      // that wrap the position several times.
      sent = 0;
      while (sent < TOTAL_BYTES) begin
         roll = $urandom_range(0, 99);
         if (roll < 8)       len = $urandom_range(40, 96);
         else if (roll < 22) len = 1;
         else                len = $urandom_range(2, 20);
         for (i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            msg_buf[i] = (roll < 10) ? 8'h00
                       : (roll < 20) ? 8'hFF
                       : 8'($urandom_range(0, 255));
         end
         steady_flow <= ($urandom_range(0, 3) == 0);
         send_message(len, $urandom_range(0, 3) == 0);
         sent += len;
      end
      req_tvalid <= 1'b0;

      // Drain: wait for every owed beat, then watch for stray ones.
      while (track.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Hashed %0d messages (%0d bytes, lengths 1..96) under random idling on both sides",
               track.messages, track.bytes_absorbed);
      $display("Checked %0d digest beats, %0d mismatches, %0d beats left owed",
               track.words_checked, track.mismatches, track.pending());
      if (track.mismatches == 0 && track.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/bmh_pkg.sv
rtl/core/bmh_dp.sv
rtl/core/bmh_ctrl.sv
rtl/core/byte_mix_hash_256.sv
tb/sv/byte_mix_hash_256_tb.sv
